@@ rtl/fcs_pkg.sv @@
// Shared types, constants and helper functions for the framed command slave.
// No dependencies; fcs_dp, fcs_ctrl, the top level and fcs_chk import this package.
package fcs_pkg;

  // Storage sizes
  localparam int RX_DEPTH  = 512;
  localparam int MEM_DEPTH = 65536;
  localparam int RX_AW     = $clog2(RX_DEPTH);
  localparam int RX_CW     = $clog2(RX_DEPTH + 1);
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  localparam int REG_DEPTH = 256;
  localparam logic [24:0] MEM_LIMIT = 25'(MEM_DEPTH);

  // Frame bytes
  localparam logic [7:0] START_BYTE = 8'hAA;
  localparam logic [7:0] ERROR_CMD  = 8'hC0;
  localparam logic [7:0] REPLY_FLAG = 8'h80;
  localparam logic [7:0] PING_DATA  = 8'h42;
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;

  // Command codes
  localparam logic [7:0] CMD_PING   = 8'h01;
  localparam logic [7:0] CMD_REG_RD = 8'h02;
  localparam logic [7:0] CMD_REG_WR = 8'h03;
  localparam logic [7:0] CMD_MEM_RD = 8'h12;
  localparam logic [7:0] CMD_MEM_WR = 8'h13;
  localparam logic [7:0] CMD_BURST  = 8'h23;
  localparam logic [7:0] CMD_LED    = 8'h70;

  // Error codes
  localparam logic [7:0] ERR_CRC     = 8'h01;
  localparam logic [7:0] ERR_UNKNOWN = 8'h02;
  localparam logic [7:0] ERR_RANGE   = 8'h06;
  localparam logic [7:0] ERR_PARAMS  = 8'h07;

  typedef enum logic [1:0] {
    EV_RX     = 2'd0,
    EV_REQ    = 2'd1,
    EV_FINISH = 2'd2,
    EV_NONE   = 2'd3
  } event_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_EXEC, ST_RD, ST_BURST, ST_BUILD, ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    OP_BUILD, OP_READ, OP_BURST
  } exec_op_t;

  // Controller to datapath
  typedef struct packed {
    logic   rx_write;
    logic   req_read;
    logic   scan_start;
    logic   scan_en;
    logic   exec;
    logic   rd_capture;
    logic   burst_en;
    logic   build_en;
    logic   clr_count;
    logic   out_load;
    event_t out_kind;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic     short_buf;
    logic     scan_drop;
    logic     scan_done;
    exec_op_t exec_op;
    logic     burst_done;
    logic     build_done;
  } dp_stat_t;

  // One byte of CRC-16/CCITT, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // Register file contents after reset
  function automatic logic [7:0] reg_reset_val(input logic [7:0] idx);
    logic [7:0] v;
    case (idx)
      8'd0:    v = 8'd64;
      8'd1:    v = 8'd42;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/fcs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/fcs_dp.sv @@
// Datapath: receive buffer, frame scan and CRC, command execution, register
// file, cartridge memory, response buffer and result registers. Uses fcs_pkg, fcs_ram.
module fcs_dp import fcs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  dp_cmd_t    cmd,
  output dp_stat_t   stat,
  input  logic [7:0] in_rx_byte,
  output logic       out_tx_valid,
  output logic [7:0] out_tx_byte,
  output logic       out_led_level
);

  // Receive buffer
  logic [RX_CW-1:0] rx_count_r;
  logic [RX_AW-1:0] rd_ptr_r, q_r;
  logic             dv_r;
  logic [7:0]       rx_rdata;
  logic             rx_we;

  assign rx_we = cmd.rx_write && (rx_count_r < RX_CW'(RX_DEPTH));

  fcs_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
    .clk(clk), .we(rx_we), .waddr(rx_count_r[RX_AW-1:0]), .wdata(in_rx_byte),
    .raddr(rd_ptr_r), .rdata(rx_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_count_r <= '0;
    end else if (cmd.clr_count) begin
      rx_count_r <= '0;
    end else if (rx_we) begin
      rx_count_r <= rx_count_r + RX_CW'(1);
    end
  end

  // Read walk over the receive buffer; q_r names the byte now on rx_rdata
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= 1'b0;
    end else begin
      dv_r <= cmd.scan_en || cmd.burst_en;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= rd_ptr_r;
    if (cmd.scan_start) begin
      rd_ptr_r <= '0;
    end else if (cmd.exec) begin
      rd_ptr_r <= RX_AW'(7);
    end else if (cmd.scan_en || cmd.burst_en) begin
      rd_ptr_r <= rd_ptr_r + RX_AW'(1);
    end
  end

  // Frame scan: header capture, CRC over seq..payload, received CRC compare
  logic [7:0]       seq_r, cmd_r, len_r, crc_hi_r;
  logic [7:0]       par_r [4];
  logic [15:0]      crc_r;
  logic             crc_ok_r;
  logic             scan_vld;
  logic [RX_AW-1:0] end_hi, end_lo, burst_last;

  assign scan_vld   = cmd.scan_en && dv_r;
  assign end_hi     = RX_AW'(len_r) + RX_AW'(4);
  assign end_lo     = RX_AW'(len_r) + RX_AW'(5);
  assign burst_last = RX_AW'(len_r) + RX_AW'(3);

  assign stat.short_buf = rx_count_r < RX_CW'(6);
  assign stat.scan_drop = scan_vld &&
                          (((q_r == RX_AW'(0)) && (rx_rdata != START_BYTE)) ||
                           ((q_r == RX_AW'(3)) &&
                            (rx_count_r < RX_CW'(6) + RX_CW'(rx_rdata))));
  assign stat.scan_done = scan_vld && (q_r >= RX_AW'(4)) && (q_r == end_lo);

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      crc_r <= CRC_INIT;
    end else if (scan_vld) begin
      if (q_r == RX_AW'(1)) seq_r <= rx_rdata;
      if (q_r == RX_AW'(2)) cmd_r <= rx_rdata;
      if (q_r == RX_AW'(3)) len_r <= rx_rdata;
      if (q_r == RX_AW'(4)) par_r[0] <= rx_rdata;
      if (q_r == RX_AW'(5)) par_r[1] <= rx_rdata;
      if (q_r == RX_AW'(6)) par_r[2] <= rx_rdata;
      if (q_r == RX_AW'(7)) par_r[3] <= rx_rdata;
      if ((q_r != RX_AW'(0)) && ((q_r <= RX_AW'(3)) || (q_r < end_hi))) begin
        crc_r <= crc_byte(crc_r, rx_rdata);
      end
      if ((q_r >= RX_AW'(4)) && (q_r == end_hi)) crc_hi_r <= rx_rdata;
      if (stat.scan_done) crc_ok_r <= (crc_r == {crc_hi_r, rx_rdata});
    end
  end

  // Command decode for the execute step
  logic [23:0] addr;
  logic        addr_ok;
  exec_op_t    ex_op;
  logic [7:0]  ex_code, ex_slot4;
  logic        ex_n, ex_set4, ex_reg_we, ex_mem_we, ex_led_we;

  assign addr    = {par_r[0], par_r[1], par_r[2]};
  assign addr_ok = {1'b0, addr} < MEM_LIMIT;

  always_comb begin
    ex_op     = OP_BUILD;
    ex_code   = cmd_r | REPLY_FLAG;
    ex_n      = 1'b0;
    ex_slot4  = PING_DATA;
    ex_set4   = 1'b0;
    ex_reg_we = 1'b0;
    ex_mem_we = 1'b0;
    ex_led_we = 1'b0;
    if (!crc_ok_r) begin
      ex_code = ERROR_CMD; ex_n = 1'b1; ex_set4 = 1'b1; ex_slot4 = ERR_CRC;
    end else begin
      case (cmd_r)
        CMD_PING: begin
          ex_n = 1'b1; ex_set4 = 1'b1;
        end
        CMD_REG_RD: begin
          if (len_r < 8'd1) begin
            ex_code = ERROR_CMD; ex_n = 1'b1; ex_set4 = 1'b1; ex_slot4 = ERR_PARAMS;
          end else begin
            ex_n = 1'b1; ex_op = OP_READ;
          end
        end
        CMD_REG_WR: begin
          if (len_r < 8'd2) begin
            ex_code = ERROR_CMD; ex_n = 1'b1; ex_set4 = 1'b1; ex_slot4 = ERR_PARAMS;
          end else begin
            ex_reg_we = 1'b1;
          end
        end
        CMD_MEM_RD: begin
          if (len_r < 8'd3) begin
            ex_code = ERROR_CMD; ex_n = 1'b1; ex_set4 = 1'b1; ex_slot4 = ERR_PARAMS;
          end else if (!addr_ok) begin
            ex_code = ERROR_CMD; ex_n = 1'b1; ex_set4 = 1'b1; ex_slot4 = ERR_RANGE;
          end else begin
            ex_n = 1'b1; ex_op = OP_READ;
          end
        end
        CMD_MEM_WR, CMD_BURST: begin
          if (len_r < 8'd4) begin
            ex_code = ERROR_CMD; ex_n = 1'b1; ex_set4 = 1'b1; ex_slot4 = ERR_PARAMS;
          end else if (!addr_ok) begin
            ex_code = ERROR_CMD; ex_n = 1'b1; ex_set4 = 1'b1; ex_slot4 = ERR_RANGE;
          end else if (cmd_r == CMD_BURST) begin
            ex_op = OP_BURST;
          end else begin
            ex_mem_we = 1'b1;
          end
        end
        CMD_LED: begin
          ex_led_we = len_r >= 8'd1;
        end
        default: begin
          ex_code = ERROR_CMD; ex_n = 1'b1; ex_set4 = 1'b1; ex_slot4 = ERR_UNKNOWN;
        end
      endcase
    end
  end

  assign stat.exec_op = ex_op;

  // Register file: RAM plus a valid bit per entry for the reset contents
  logic [REG_DEPTH-1:0] reg_vld_r;
  logic [7:0]           reg_rdata, reg_value;
  logic                 reg_we;

  assign reg_we    = cmd.exec && ex_reg_we;
  assign reg_value = reg_vld_r[par_r[0]] ? reg_rdata : reg_reset_val(par_r[0]);

  fcs_ram #(.WIDTH(8), .DEPTH(REG_DEPTH)) u_reg_ram (
    .clk(clk), .we(reg_we), .waddr(par_r[0]), .wdata(par_r[1]),
    .raddr(par_r[0]), .rdata(reg_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_vld_r <= '0;
    end else if (reg_we) begin
      reg_vld_r[par_r[0]] <= 1'b1;
    end
  end

  // Cartridge memory: single write or burst stream
  logic [24:0]       bw_addr_r;
  logic              burst_vld, mem_we;
  logic [MEM_AW-1:0] mem_waddr;
  logic [7:0]        mem_wdata, mem_rdata;

  assign burst_vld     = cmd.burst_en && dv_r;
  assign stat.burst_done = burst_vld && (q_r == burst_last);
  assign mem_we    = (cmd.exec && ex_mem_we) || (burst_vld && (bw_addr_r < MEM_LIMIT));
  assign mem_waddr = cmd.exec ? addr[MEM_AW-1:0] : bw_addr_r[MEM_AW-1:0];
  assign mem_wdata = cmd.exec ? par_r[3] : rx_rdata;

  fcs_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_mem_ram (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(addr[MEM_AW-1:0]), .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      bw_addr_r <= {1'b0, addr};
    end else if (burst_vld) begin
      bw_addr_r <= bw_addr_r + 25'd1;
    end
  end

  // LED
  logic led_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_r <= 1'b0;
    end else if (cmd.exec && ex_led_we) begin
      led_r <= par_r[0] != 8'd0;
    end
  end

  // Response buffer: header on execute, CRC one byte per cycle, then trailer
  logic [7:0]  resp_r [8];
  logic [2:0]  resp_len_r, resp_pos_r, bi_r;
  logic        n_r;
  logic [15:0] crc_b_r, crc_b_nxt;
  logic        tx_avail;

  assign crc_b_nxt       = crc_byte(crc_b_r, resp_r[bi_r]);
  assign stat.build_done = cmd.build_en && (bi_r == (3'd3 + {2'b00, n_r}));
  assign tx_avail        = resp_pos_r < resp_len_r;

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      resp_r[0] <= START_BYTE;
      resp_r[1] <= seq_r;
      resp_r[2] <= ex_code;
      resp_r[3] <= {7'd0, ex_n};
      if (ex_set4) resp_r[4] <= ex_slot4;
      n_r     <= ex_n;
      bi_r    <= 3'd1;
      crc_b_r <= CRC_INIT;
    end else if (cmd.rd_capture) begin
      resp_r[4] <= (cmd_r == CMD_MEM_RD) ? mem_rdata : reg_value;
    end else if (cmd.build_en) begin
      crc_b_r <= crc_b_nxt;
      bi_r    <= bi_r + 3'd1;
      if (stat.build_done) begin
        resp_r[3'd4 + {2'b00, n_r}] <= crc_b_nxt[15:8];
        resp_r[3'd5 + {2'b00, n_r}] <= crc_b_nxt[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resp_len_r <= '0;
      resp_pos_r <= '0;
    end else if (stat.build_done) begin
      resp_len_r <= 3'd6 + {2'b00, n_r};
      resp_pos_r <= '0;
    end else if (cmd.req_read && tx_avail) begin
      resp_pos_r <= resp_pos_r + 3'd1;
    end
  end

  // Result registers
  logic       out_tx_valid_r, out_led_r;
  logic [7:0] out_tx_byte_r;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_tx_valid_r <= cmd.out_kind == EV_REQ;
      out_tx_byte_r  <= ((cmd.out_kind == EV_REQ) && tx_avail) ? resp_r[resp_pos_r] : 8'd0;
      out_led_r      <= led_r;
    end
  end

  assign out_tx_valid  = out_tx_valid_r;
  assign out_tx_byte   = out_tx_byte_r;
  assign out_led_level = out_led_r;

endmodule

@@ rtl/fcs_ctrl.sv @@
// Controller: input/output handshake and the sequence that handles a finish
// event (scan, execute, read, burst, build). Uses fcs_pkg.
module fcs_ctrl import fcs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_event_kind,
  output logic       out_valid,
  input  logic       out_ready,
  output dp_cmd_t    cmd,
  input  dp_stat_t   stat
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  // State and result-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.out_kind = EV_FINISH;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.out_kind = event_t'(in_event_kind);
          case (event_t'(in_event_kind))
            EV_RX: begin
              cmd.rx_write = 1'b1;
              cmd.out_load = 1'b1;
            end
            EV_REQ: begin
              cmd.req_read = 1'b1;
              cmd.out_load = 1'b1;
            end
            EV_FINISH: begin
              if (stat.short_buf) begin
                cmd.clr_count = 1'b1;
                cmd.out_load  = 1'b1;
              end else begin
                cmd.scan_start = 1'b1;
                state_nxt      = ST_SCAN;
              end
            end
            default: begin
              cmd.out_load = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (stat.scan_drop) begin
          state_nxt = ST_DONE;
        end else if (stat.scan_done) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        case (stat.exec_op)
          OP_READ:  state_nxt = ST_RD;
          OP_BURST: state_nxt = ST_BURST;
          default:  state_nxt = ST_BUILD;
        endcase
      end
      ST_RD: begin
        cmd.rd_capture = 1'b1;
        state_nxt      = ST_BUILD;
      end
      ST_BURST: begin
        cmd.burst_en = 1'b1;
        if (stat.burst_done) state_nxt = ST_BUILD;
      end
      ST_BUILD: begin
        cmd.build_en = 1'b1;
        if (stat.build_done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        cmd.clr_count = 1'b1;
        cmd.out_load  = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

endmodule

@@ rtl/framed_command_slave_crc16.sv @@
// Bus target that buffers received bytes, checks a CRC-16/CCITT framed command
// on the finish event, runs it and streams the response frame on request
// events. Receive, request and ignored events each give one result straight from
// the idle state. A finish event on six or more buffered bytes walks the receive
// buffer through its single read port to scan the frame; a burst write walks its
// burst data bytes again to stream them into the cartridge memory. One item
// is handled at a time; the result register lets a new item enter while the last
// result is still being taken. Uses fcs_pkg, fcs_ctrl, fcs_dp.
module framed_command_slave_crc16 import fcs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_event_kind,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_tx_valid,
  output logic [7:0] out_tx_byte,
  output logic       out_led_level
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  fcs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_event_kind(in_event_kind),
    .out_valid(out_valid), .out_ready(out_ready),
    .cmd(cmd), .stat(stat)
  );

  fcs_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_rx_byte(in_rx_byte),
    .out_tx_valid(out_tx_valid), .out_tx_byte(out_tx_byte),
    .out_led_level(out_led_level)
  );

endmodule

@@ rtl/fcs_chk.sv @@
// Port-level checks for the framed command slave, bound to the top level.
// Uses fcs_pkg.
module fcs_chk import fcs_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_event_kind,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_tx_valid,
  input logic [7:0] out_tx_byte,
  input logic       out_led_level
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tx_byte) && $stable(out_tx_valid))
    else $error("result changed while stalled");

  // Non-request results carry a zero byte
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_tx_valid |-> out_tx_byte == 8'd0)
    else $error("nonzero byte on non-request result");

  // Simple events answer in the next cycle
  a_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_event_kind != EV_FINISH) |=> out_valid)
    else $error("simple item gave no result");

  // A request result is flagged as such
  a_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_event_kind == EV_REQ) |=> out_tx_valid)
    else $error("request result not flagged");

  // LED level only moves on finish results
  a_led: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_event_kind != EV_FINISH) && out_valid && out_ready
    |=> out_led_level == $past(out_led_level))
    else $error("LED changed on a non-finish item");

endmodule

bind framed_command_slave_crc16 fcs_chk u_fcs_chk (.*);
